/* hdl/adx_pkg.sv */
package adx_pkg;

    // Field widths.
    localparam int IndexWidth = 12;
    localparam int ValueWidth = 32;
    localparam int NormWidth  = 31;
    localparam int RateWidth  = 24;
    localparam int BetaWidth  = 16;
    localparam int CfgIdxWidth = 2;
    localparam int CfgDataWidth = 32;

    // Store depth default.
    localparam int DefaultWeightDepth = 4096;

    // Register indexes.
    localparam logic [CfgIdxWidth-1:0] RegLearnRate  = 2'd0;
    localparam logic [CfgIdxWidth-1:0] RegFirstDecay = 2'd1;
    localparam logic [CfgIdxWidth-1:0] RegNormDecay  = 2'd2;
    localparam logic [CfgIdxWidth-1:0] RegStabilizer = 2'd3;

    // Register reset values.
    localparam logic [RateWidth-1:0] LearnRateReset  = 24'd33554;
    localparam logic [BetaWidth-1:0] FirstDecayReset = 16'd58982;
    localparam logic [BetaWidth-1:0] NormDecayReset  = 16'd65470;
    localparam logic [BetaWidth-1:0] StabilizerReset = 16'd1;

    // Widths of the step dividend and quotient, and of the divisor.
    localparam int NumWidth = 64;
    localparam int DenWidth = 48;

    // One item handed from the front part to the back part.
    typedef struct packed {
        logic                         in_range;
        logic [IndexWidth-1:0]        index;
        logic signed [ValueWidth-1:0] value;
        logic signed [ValueWidth-1:0] grad;
        logic                         pass_end;
    } adx_item_t;

endpackage

/* hdl/adamax_optimizer_update_top.sv */
// An item passes the queue hand-over, a store read, three update steps, a numerator
// step, then a 64-step bit-serial divider; out-of-range items go from the store read
// straight to the output, and a zero denominator skips the divider.
// The back part works on one item at a time; the two-entry input queue holds more.
// Reset (aresetn low, synchronous) restores the registers; then a clearing pass over
// all WEIGHT_DEPTH entries zeroes both stores before items leave the input queue.
module adamax_optimizer_update_top #(
    parameter int WEIGHT_DEPTH = adx_pkg::DefaultWeightDepth
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [adx_pkg::IndexWidth-1:0]        s_weight_index,
    input  logic signed [adx_pkg::ValueWidth-1:0] s_weight_value,
    input  logic signed [adx_pkg::ValueWidth-1:0] s_gradient,
    input  logic                                  s_pass_end,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [adx_pkg::CfgIdxWidth-1:0]       cfg_index,
    input  logic [adx_pkg::CfgDataWidth-1:0]      cfg_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [adx_pkg::ValueWidth-1:0] m_new_weight,
    output logic                                  m_saturated
);
    import adx_pkg::*;

    adx_item_t q_item;
    logic      q_valid, q_ready;

    assign cfg_ready = 1'b1;

    adx_front #(.WEIGHT_DEPTH(WEIGHT_DEPTH)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_weight_index, .s_weight_value,
        .s_gradient, .s_pass_end, .q_valid, .q_ready, .q_item
    );

    adx_back #(.WEIGHT_DEPTH(WEIGHT_DEPTH)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_item,
        .cfg_valid, .cfg_index, .cfg_data,
        .m_valid, .m_ready, .m_new_weight, .m_saturated
    );

endmodule

/* hdl/adx_front.sv */
module adx_front #(
    parameter int WEIGHT_DEPTH = adx_pkg::DefaultWeightDepth
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [adx_pkg::IndexWidth-1:0]        s_weight_index,
    input  logic signed [adx_pkg::ValueWidth-1:0] s_weight_value,
    input  logic signed [adx_pkg::ValueWidth-1:0] s_gradient,
    input  logic                                  s_pass_end,
    output logic                                  q_valid,
    input  logic                                  q_ready,
    output adx_pkg::adx_item_t                    q_item
);
    import adx_pkg::*;

    localparam int QDepth = 2;

    adx_item_t        fifo_reg [QDepth];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    adx_item_t        item_in;
    logic             push, pop;

    // Classify the incoming item by its index range.
    always_comb begin
        item_in.in_range = ({20'd0, s_weight_index} < 32'(WEIGHT_DEPTH));
        item_in.index    = s_weight_index;
        item_in.value    = s_weight_value;
        item_in.grad     = s_gradient;
        item_in.pass_end = s_pass_end;
    end

    assign s_ready = (count_reg != 2'(QDepth));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_item  = fifo_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping of the two-entry queue.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

/* hdl/adx_divider.sv */
module adx_divider (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [adx_pkg::NumWidth-1:0]        dividend,
    input  logic [adx_pkg::DenWidth-1:0]        divisor,
    output logic                                done,
    output logic [adx_pkg::NumWidth-1:0]        quotient
);
    import adx_pkg::*;

    localparam int CntWidth = $clog2(NumWidth + 1);

    logic [NumWidth-1:0]  quot_reg, quot_next;
    logic [DenWidth:0]    rem_reg, rem_next;
    logic [DenWidth-1:0]  div_reg;
    logic [CntWidth-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DenWidth:0]    trial;

    assign done     = done_reg;
    assign quotient = quot_reg;

    // One quotient bit per cycle, restoring form.
    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DenWidth-1:0], quot_reg[NumWidth-1]};
        if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = CntWidth'(NumWidth);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next  = trial - {1'b0, div_reg};
                quot_next = {quot_reg[NumWidth-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_reg[NumWidth-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntWidth'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start) begin
            div_reg <= divisor;
        end
    end

endmodule

/* hdl/adx_back.sv */
module adx_back #(
    parameter int WEIGHT_DEPTH = adx_pkg::DefaultWeightDepth
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  q_valid,
    output logic                                  q_ready,
    input  adx_pkg::adx_item_t                    q_item,
    input  logic                                  cfg_valid,
    input  logic [adx_pkg::CfgIdxWidth-1:0]       cfg_index,
    input  logic [adx_pkg::CfgDataWidth-1:0]      cfg_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [adx_pkg::ValueWidth-1:0] m_new_weight,
    output logic                                  m_saturated
);
    import adx_pkg::*;

    localparam int AddrWidth = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_READ  = 9'b000000100,
        ST_MUL   = 9'b000001000,
        ST_UPD   = 9'b000010000,
        ST_DEN   = 9'b000100000,
        ST_NUM   = 9'b001000000,
        ST_DIV   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers and the running power of beta one.
    logic [RateWidth-1:0] rate_reg;
    logic [BetaWidth-1:0] b1_reg, b2_reg, eps_reg, pow_reg;

    // Per-weight stores.
    logic signed [ValueWidth-1:0] moment_mem [WEIGHT_DEPTH];
    logic [NormWidth-1:0]         norm_mem [WEIGHT_DEPTH];
    logic signed [ValueWidth-1:0] m_rd_reg;
    logic [NormWidth-1:0]         u_rd_reg;
    logic [AddrWidth-1:0]         clr_addr_reg;

    adx_item_t item_reg;
    logic [AddrWidth-1:0] addr;

    // Working registers.
    logic signed [49:0]     pm1_reg, pm2_reg;
    logic [47:0]            pu_reg;
    logic signed [ValueWidth-1:0] m_new_reg;
    logic [NormWidth-1:0]   u_new_reg;
    logic [DenWidth-1:0]    den_reg;
    logic [NumWidth-1:0]    num_reg;
    logic                   out_valid_reg;
    logic signed [ValueWidth-1:0] out_w_reg;
    logic                   out_sat_reg;

    logic                   div_start;
    logic                   div_done;
    logic [NumWidth-1:0]    div_q;

    logic signed [50:0]     msum;
    logic signed [34:0]     mshift;
    logic [32:0]            gabs;
    logic [NormWidth-1:0]   gsat;
    logic [NormWidth-1:0]   udec;
    logic [31:0]            mabs;
    logic [NumWidth-1:0]    q_clip;
    logic signed [35:0]     res_wide;

    assign addr    = AddrWidth'(item_reg.index);
    assign q_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_new_weight = out_w_reg;
    assign m_saturated  = out_sat_reg;

    // Moment and norm updates from the registered products, and the clipped step on the weight.
    always_comb begin
        msum   = 51'(pm1_reg) + 51'(pm2_reg) + 51'sd32768;
        mshift = 35'(msum >>> 16);
        gabs   = item_reg.grad[ValueWidth-1] ? 33'(-34'(item_reg.grad))
                                             : 33'(item_reg.grad);
        gsat   = (gabs > 33'h7FFFFFFF) ? 31'h7FFFFFFF : gabs[NormWidth-1:0];
        udec   = NormWidth'((pu_reg + 48'd32768) >> 16);
        mabs   = m_new_reg[ValueWidth-1] ? 32'(-33'(m_new_reg)) : 32'(m_new_reg);
        q_clip = (div_q > 64'h200000000) ? 64'h200000000 : div_q;
        res_wide = m_new_reg[ValueWidth-1]
                   ? 36'(item_reg.value) + 36'(q_clip[33:0])
                   : 36'(item_reg.value) - 36'(q_clip[33:0]);
    end

    assign div_start = (state_reg == ST_NUM);

    adx_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_reg + 64'(den_reg >> 1)),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == AddrWidth'(WEIGHT_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (!item_reg.in_range) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: state_next = ST_UPD;
            ST_UPD: state_next = ST_DEN;
            ST_DEN: state_next = ST_NUM;
            ST_NUM: begin
                state_next = (den_reg == '0) ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            rate_reg      <= LearnRateReset;
            b1_reg        <= FirstDecayReset;
            b2_reg        <= NormDecayReset;
            eps_reg       <= StabilizerReset;
            pow_reg       <= FirstDecayReset;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            // A new result replaces the one leaving; otherwise an accepted result clears valid.
            if (state_reg == ST_OUT && (!out_valid_reg || m_ready)) begin
                out_valid_reg <= 1'b1;
                if (item_reg.pass_end) begin
                    pow_reg <= BetaWidth'((32'(pow_reg) * 32'(b1_reg) + 32'd32768) >> 16);
                end
            end else if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            // Configuration writes.
            if (cfg_valid) begin
                case (cfg_index)
                    RegLearnRate:  rate_reg <= cfg_data[RateWidth-1:0];
                    RegFirstDecay: begin
                        b1_reg  <= cfg_data[BetaWidth-1:0];
                        pow_reg <= cfg_data[BetaWidth-1:0];
                    end
                    RegNormDecay:  b2_reg <= cfg_data[BetaWidth-1:0];
                    RegStabilizer: eps_reg <= cfg_data[BetaWidth-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid) begin
            item_reg <= q_item;
        end
        if (state_reg == ST_READ) begin
            m_rd_reg <= moment_mem[addr];
            u_rd_reg <= norm_mem[addr];
        end
        if (state_reg == ST_MUL) begin
            pm1_reg <= 50'(m_rd_reg) * $signed({1'b0, b1_reg});
            pm2_reg <= 50'(item_reg.grad) * $signed(18'(17'h10000 - 17'(b1_reg)));
            pu_reg  <= 48'(u_rd_reg) * 48'(b2_reg);
        end
        if (state_reg == ST_UPD) begin
            m_new_reg <= mshift[ValueWidth-1:0];
            u_new_reg <= (udec > gsat) ? udec : gsat;
        end
        if (state_reg == ST_DEN) begin
            den_reg <= 48'(u_new_reg) * 48'(17'h10000 - 17'(pow_reg))
                       + {16'd0, eps_reg, 16'd0};
            num_reg <= {56'(rate_reg) * 56'(mabs), 8'd0};
        end
        if (state_reg == ST_OUT && (!out_valid_reg || m_ready)) begin
            if (!item_reg.in_range) begin
                out_w_reg   <= item_reg.value;
                out_sat_reg <= 1'b0;
            end else if (den_reg == '0) begin
                out_sat_reg <= 1'b1;
                if (m_new_reg > 0) begin
                    out_w_reg <= 32'sh80000000;
                end else if (m_new_reg < 0) begin
                    out_w_reg <= 32'sh7FFFFFFF;
                end else begin
                    out_w_reg <= item_reg.value;
                end
            end else if (res_wide > 36'sh07FFFFFFF) begin
                out_w_reg   <= 32'sh7FFFFFFF;
                out_sat_reg <= 1'b1;
            end else if (res_wide < -36'sh080000000) begin
                out_w_reg   <= 32'sh80000000;
                out_sat_reg <= 1'b1;
            end else begin
                out_w_reg   <= res_wide[ValueWidth-1:0];
                out_sat_reg <= 1'b0;
            end
        end
    end

    // Store writes: clearing pass after reset, then the updated state.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            moment_mem[clr_addr_reg] <= '0;
            norm_mem[clr_addr_reg]   <= '0;
        end else if (state_reg == ST_DEN) begin
            moment_mem[addr] <= m_new_reg;
            norm_mem[addr]   <= u_new_reg;
        end
    end

endmodule

/* hdl/adx_checker.sv */
module adx_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_new_weight,
    input logic        m_saturated,
    input logic        cfg_ready
);
    // The result is held while stalled.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_weight) && $stable(m_saturated))
        else $error("result changed while stalled");

    // Configuration is always taken.
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("configuration port stalled");

    // No result in the cycle after reset.
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result after reset");

    // The input queue is empty, and so ready, right after reset.
    a_rdy: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");
endmodule

bind adamax_optimizer_update_top adx_checker u_chk (
    .aclk, .aresetn, .s_ready, .m_valid, .m_ready,
    .m_new_weight, .m_saturated, .cfg_ready
);

/* test/testbench.sv */
class weight_update_board;
    localparam int Depth = adx_pkg::DefaultWeightDepth;

    // Shadow copy of the block's registers and stores.
    int unsigned rate;
    int unsigned beta1;
    int unsigned beta2;
    int unsigned eps;
    int unsigned beta1_power;
    int moment[Depth];
    int unsigned norm[Depth];

    // Updated weights still waiting to come out of the block.
    logic signed [31:0] weight_queue[$];
    bit sat_queue[$];
    int errors;

    function new();
        rate = adx_pkg::LearnRateReset;
        beta1 = adx_pkg::FirstDecayReset;
        beta2 = adx_pkg::NormDecayReset;
        eps = adx_pkg::StabilizerReset;
        beta1_power = beta1;
        errors = 0;
        foreach (moment[i]) begin
            moment[i] = 0;
            norm[i] = 0;
        end
    endfunction

    function void write_reg(logic [adx_pkg::CfgIdxWidth-1:0] idx, logic [31:0] data);
        case (idx)
            adx_pkg::RegLearnRate: rate = data[23:0];
            adx_pkg::RegFirstDecay: begin
                beta1 = data[15:0];
                beta1_power = beta1;
            end
            adx_pkg::RegNormDecay: beta2 = data[15:0];
            adx_pkg::RegStabilizer: eps = data[15:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return weight_queue.size();
    endfunction

    // Works out the updated weight for one accepted item.
    function void note_item(logic [11:0] idx, logic signed [31:0] value,
                            logic signed [31:0] grad, logic last);
        longint param;
        longint g;
        longint m_new;
        longint result;
        longint unsigned gabs;
        longint unsigned u_dec;
        longint unsigned u_new;
        longint unsigned den;
        longint unsigned mabs;
        longint unsigned num;
        longint unsigned q;
        bit sat;
        param = value;
        g = grad;
        result = param;
        sat = 0;
        if (idx < Depth) begin
            m_new = (longint'(beta1) * moment[idx] + longint'(65536 - beta1) * g
                     + 32768) >>> 16;
            gabs = (g < 0) ? -g : g;
            if (gabs > 64'h7FFF_FFFF) gabs = 64'h7FFF_FFFF;
            u_dec = (longint'(beta2) * norm[idx] + 32768) >> 16;
            u_new = (u_dec > gabs) ? u_dec : gabs;
            moment[idx] = int'(m_new);
            norm[idx] = int'(u_new);
            den = u_new * longint'(65536 - beta1_power) + (longint'(eps) << 16);
            if (den == 0) begin
                // A zero denominator saturates in the direction opposing the moment.
                sat = 1;
                if (m_new > 0) result = -64'sd2147483648;
                else if (m_new < 0) result = 64'sd2147483647;
            end else begin
                mabs = (m_new < 0) ? -m_new : m_new;
                num = (longint'(rate) * mabs) << 8;
                q = (num + (den >> 1)) / den;
                if (q > 64'h2_0000_0000) q = 64'h2_0000_0000;
                result = (m_new < 0) ? param + longint'(q) : param - longint'(q);
                if (result > 64'sd2147483647) begin
                    result = 64'sd2147483647;
                    sat = 1;
                end else if (result < -64'sd2147483648) begin
                    result = -64'sd2147483648;
                    sat = 1;
                end
            end
        end
        if (last) beta1_power = (beta1_power * beta1 + 32768) >> 16;
        weight_queue.push_back(result[31:0]);
        sat_queue.push_back(sat);
    endfunction

    // Compares one result with the oldest updated weight.
    function void check_result(logic signed [31:0] weight, logic sat);
        logic signed [31:0] exp_w;
        bit exp_s;
        if (weight_queue.size() == 0) begin
            $error("result with no item outstanding: new_weight %0d", weight);
            errors++;
            return;
        end
        exp_w = weight_queue.pop_front();
        exp_s = sat_queue.pop_front();
        if (weight !== exp_w) begin
            $error("new_weight: expected %0d, actual %0d", exp_w, weight);
            errors++;
        end
        if (sat !== exp_s) begin
            $error("saturated: expected %0d, actual %0d", exp_s, sat);
            errors++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 1000000;
    localparam int DrainCycles = 100;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [11:0] s_weight_index = 0;
    logic signed [31:0] s_weight_value = 0;
    logic signed [31:0] s_gradient = 0;
    logic s_pass_end = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [adx_pkg::CfgIdxWidth-1:0] cfg_index = adx_pkg::RegLearnRate;
    logic [31:0] cfg_data = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [31:0] m_new_weight;
    logic m_saturated;

    weight_update_board board = new();
    bit quiet = 0;
    bit long_hold = 0;
    int cycles = 0;

    adamax_optimizer_update_top dut (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("** adamax_optimizer_update_top: FAILED **");
            $finish;
        end
    end

    // Record accepted items and check accepted results.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            board.note_item(s_weight_index, s_weight_value, s_gradient, s_pass_end);
        if (aresetn && m_valid && m_ready)
            board.check_result(m_new_weight, m_saturated);
    end

    // The receiver stalls in bursts, and once for a long stretch.
    initial begin
        forever begin
            if (long_hold) begin
                m_ready <= 0;
                repeat (400) @(posedge aclk);
                long_hold = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_ready <= 1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_item(logic [11:0] idx, logic signed [31:0] value,
                             logic signed [31:0] grad, logic last);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1;
        s_weight_index <= idx;
        s_weight_value <= value;
        s_gradient <= grad;
        s_pass_end <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Waits until every result is back, then lets the pipeline settle.
    task automatic wait_idle();
        s_valid <= 0;
        // Wait for the clock first, so the last accepted item is already on the board.
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_reg(logic [adx_pkg::CfgIdxWidth-1:0] idx, logic [31:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        board.write_reg(idx, data);
        @(posedge aclk);
    endtask

    task automatic set_regs(logic [23:0] rate, logic [15:0] b1, logic [15:0] b2,
                            logic [15:0] eps);
        write_reg(adx_pkg::RegLearnRate, 32'(rate));
        write_reg(adx_pkg::RegFirstDecay, 32'(b1));
        write_reg(adx_pkg::RegNormDecay, 32'(b2));
        write_reg(adx_pkg::RegStabilizer, 32'(eps));
    endtask

    function automatic logic signed [31:0] random_grad();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $signed($urandom_range(0, 131072)) - 65536;
            2: return 0;
            3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom) >>> $urandom_range(0, 30);
        endcase
    endfunction

    // Random items, mostly on a small set of weights so the stores build up.
    task automatic random_items(int count);
        logic [11:0] idx;
        repeat (count) begin
            idx = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                               : 12'($urandom_range(0, 15));
            send_item(idx, $urandom, random_grad(), $urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;

        // Directed items at the reset settings: field extremes.
        send_item(12'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_item(12'd4095, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
        send_item(12'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        send_item(12'd4095, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
        send_item(12'd1, 32'sh0, 32'sh0, 1'b0);
        send_item(12'd1, 32'sh0001_0000, -32'sh0001_0000, 1'b1);
        send_item(12'd2, -32'sh1, 32'sh1, 1'b0);
        send_item(12'd2, 32'sh0, 32'sh0, 1'b0);
        wait_idle();

        // Zero denominator: no norm decay and no stabiliser.
        set_regs(24'd16777215, 16'd65535, 16'd0, 16'd0);
        send_item(12'd8, 32'sh1234_5678, 32'sh0010_0000, 1'b0);
        send_item(12'd8, 32'sh1234_5678, 32'sh0, 1'b0);
        send_item(12'd9, -32'sh1234_5678, -32'sh0010_0000, 1'b0);
        send_item(12'd9, -32'sh1234_5678, 32'sh0, 1'b0);
        send_item(12'd10, 32'sh0BAD_F00D, 32'sh0, 1'b1);
        send_item(12'd11, 32'sh7FFF_0000, -32'sh7FFF_0000, 1'b1);
        wait_idle();

        // Rewriting beta one restarts the power sequence.
        set_regs(24'd1, 16'd0, 16'd65535, 16'd65535);
        send_item(12'd12, 32'sh0, 32'sh7FFF_FFFF, 1'b1);
        send_item(12'd12, 32'sh0, 32'sh8000_0000, 1'b1);
        wait_idle();
        write_reg(adx_pkg::RegFirstDecay, 32'd32768);
        send_item(12'd12, 32'sh0, 32'sh4000_0000, 1'b1);
        wait_idle();

        // Random phases across a spread of settings.
        set_regs(adx_pkg::LearnRateReset, adx_pkg::FirstDecayReset,
                 adx_pkg::NormDecayReset, adx_pkg::StabilizerReset);
        random_items(250);
        // Long receiver hold-off while items keep coming.
        long_hold = 1;
        random_items(30);
        wait_idle();
        set_regs(24'd16777215, 16'd65535, 16'd65535, 16'd0);
        random_items(200);
        wait_idle();
        set_regs(24'd1, 16'd0, 16'd0, 16'd65535);
        random_items(150);
        wait_idle();
        set_regs(24'($urandom_range(1, 16777215)), 16'($urandom), 16'($urandom),
                 16'($urandom));
        random_items(200);
        wait_idle();
        set_regs(24'($urandom_range(1, 16777215)), 16'($urandom_range(60000, 65535)),
                 16'($urandom_range(60000, 65535)), 16'($urandom_range(0, 4)));
        random_items(200);
        // Final stretch with no idling on either side.
        quiet = 1;
        random_items(150);
        wait_idle();

        if (board.errors == 0) begin
            $display("** adamax_optimizer_update_top: PASSED **");
        end else begin
            $display("** adamax_optimizer_update_top: FAILED **");
        end
        $finish;
    end
endmodule
